// File: hw/rtl/sfsd_pkg.sv
// Shared types and constants for the source flood and scan detector.
package sfsd_pkg;

	// Widest entry index and port-fill count over the supported parameter range
	localparam int SFSD_IDX_W  = 12;
	localparam int SFSD_FILL_W = 9;

	localparam logic [1:0] CFG_FLOOD_THR = 2'd0;
	localparam logic [1:0] CFG_SCAN_THR  = 2'd1;
	localparam logic [1:0] CFG_LARGE     = 2'd2;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [15:0] dst_port;
		logic [15:0] pkt_length;
	} sfsd_in_t;

	typedef struct packed {
		logic flood_alert;
		logic scan_alert;
		logic large_alert;
		logic newly_blocked;
		logic source_blocked;
		logic table_full;
	} sfsd_out_t;

	// Search token passed from cell to cell
	typedef struct packed {
		logic                   go;
		logic [31:0]            addr;
		logic                   hit;
		logic [SFSD_IDX_W-1:0]  hit_idx;
		logic [16:0]            count;
		logic                   blocked;
		logic [SFSD_FILL_W-1:0] fill;
		logic                   free;
		logic [SFSD_IDX_W-1:0]  free_idx;
	} sfsd_tok_t;

	// Entry write broadcast to all cells
	typedef struct packed {
		logic                   en;
		logic [SFSD_IDX_W-1:0]  idx;
		logic [31:0]            addr;
		logic [16:0]            count;
		logic                   blocked;
		logic [SFSD_FILL_W-1:0] fill;
	} sfsd_upd_t;

endpackage

// File: hw/rtl/sfsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfsd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/sfsd_cell.sv
// One source table entry; matches the passing search token, offers itself as free if empty, and forwards it.
module sfsd_cell #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sfsd_pkg::sfsd_tok_t tin,
	output sfsd_pkg::sfsd_tok_t tout,
	input  sfsd_pkg::sfsd_upd_t upd
);
	import sfsd_pkg::*;

	logic                   valid_q;
	logic [31:0]            addr_q;
	logic [16:0]            count_q;
	logic                   blocked_q;
	logic [SFSD_FILL_W-1:0] fill_q;
	sfsd_tok_t              tok_q;
	sfsd_tok_t              tnext;

	always_comb begin
		tnext = tin;
		if (tin.go && valid_q && !tin.hit && addr_q == tin.addr) begin
			tnext.hit     = 1'b1;
			tnext.hit_idx = SFSD_IDX_W'(IDX);
			tnext.count   = count_q;
			tnext.blocked = blocked_q;
			tnext.fill    = fill_q;
		end
		if (tin.go && !valid_q && !tin.free) begin
			tnext.free     = 1'b1;
			tnext.free_idx = SFSD_IDX_W'(IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tnext;
			if (upd.en && upd.idx == SFSD_IDX_W'(IDX)) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en && upd.idx == SFSD_IDX_W'(IDX)) begin
			addr_q    <= upd.addr;
			count_q   <= upd.count;
			blocked_q <= upd.blocked;
			fill_q    <= upd.fill;
		end
	end

	assign tout = tok_q;
endmodule

// File: hw/rtl/source_flood_scan_detector.sv
// Top level: per-source flood, port-scan and large-packet detector.
//
//  channel | signals                          | dir | payload
//  input   | in_valid, in_ready, in_data      | in  | sfsd_in_t
//  result  | out_valid, out_ready, out_data   | out | sfsd_out_t
//  config  | cfg_valid, cfg_ready, cfg_index, | in  | 2-bit index, 16-bit data
//          | cfg_data                         |     |
//
// An item's token walks the cell chain, then each stored port is compared in turn
// (one RAM read and compare each, stopping at a match), then the entry is updated
// and the result presented.
// Reset clears the entry valid bits and the chain at once; no clearing pass.
// in_ready is high only while idle; a held result does not block the next
// transaction until its own result is ready to load.
module source_flood_scan_detector #(
	parameter int SOURCE_ENTRIES   = 64,
	parameter int PORTS_PER_SOURCE = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sfsd_pkg::sfsd_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sfsd_pkg::sfsd_out_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import sfsd_pkg::*;

	localparam int IW    = SOURCE_ENTRIES > 1 ? $clog2(SOURCE_ENTRIES) : 1;
	localparam int FW    = $clog2(PORTS_PER_SOURCE + 1);
	localparam int DEPTH = SOURCE_ENTRIES * PORTS_PER_SOURCE;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SRCH = 6'b000010,
		S_RD   = 6'b000100,
		S_CMP  = 6'b001000,
		S_PRT  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t      state_q;
	sfsd_in_t    in_q;
	logic        start_q;
	logic [15:0] flood_thr_q;
	logic [4:0]  scan_thr_q;
	logic [15:0] large_q;
	logic [IW-1:0] slot_q;
	logic [16:0] cnt_q;
	logic        blk_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] k_q;
	logic        full_q;
	logic        present_q;
	sfsd_out_t   res_q;
	sfsd_out_t   out_q;
	logic        out_valid_q;

	sfsd_tok_t   tok [SOURCE_ENTRIES+1];
	sfsd_upd_t   upd;

	logic [AW-1:0] base;
	logic [AW-1:0] raddr;
	logic [15:0]   rdata;
	logic          we;

	logic [16:0]   cnt1;
	logic          flood;
	logic          add;
	logic [FW-1:0] fill1;
	logic          scan;
	logic          oversize;
	logic          alert;
	logic [FW-1:0] k1;

	// Token enters the chain the cycle after acceptance
	assign tok[0] = '{go: start_q, addr: in_q.src_addr, default: '0};

	for (genvar i = 0; i < SOURCE_ENTRIES; i++) begin : g_cell
		sfsd_cell #(.IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tin    (tok[i]),
			.tout   (tok[i+1]),
			.upd    (upd)
		);
	end

	assign base  = AW'(32'(slot_q) * PORTS_PER_SOURCE);
	assign raddr = base + AW'(k_q);
	assign k1    = k_q + FW'(1);

	assign cnt1     = cnt_q + 17'd1;
	assign flood    = cnt1 > {1'b0, flood_thr_q};
	assign add      = !present_q && (32'(fill_q) < PORTS_PER_SOURCE);
	assign fill1    = add ? fill_q + FW'(1) : fill_q;
	assign scan     = 32'(fill1) > 32'(scan_thr_q);
	assign oversize = in_q.pkt_length > large_q;
	assign alert    = flood || scan || oversize;
	assign we       = (state_q == S_PRT) && !full_q && add;

	sfsd_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ports (
		.clk   (clk),
		.we    (we),
		.waddr (base + AW'(fill_q)),
		.wdata (in_q.dst_port),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		upd         = '0;
		upd.en      = (state_q == S_PRT) && !full_q;
		upd.idx     = SFSD_IDX_W'(slot_q);
		upd.addr    = in_q.src_addr;
		upd.count   = flood ? 17'd0 : cnt1;
		upd.blocked = blk_q || alert;
		upd.fill    = scan ? '0 : SFSD_FILL_W'(fill1);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flood_thr_q <= 16'd100;
			scan_thr_q  <= 5'd10;
			large_q     <= 16'd1500;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FLOOD_THR: flood_thr_q <= cfg_data;
				CFG_SCAN_THR:  scan_thr_q  <= cfg_data[4:0];
				CFG_LARGE:     large_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						start_q <= 1'b1;
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (tok[SOURCE_ENTRIES].go) begin
						if (tok[SOURCE_ENTRIES].hit &&
						    tok[SOURCE_ENTRIES].fill != '0) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_PRT;
						end
					end
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (rdata == in_q.dst_port || k1 == fill_q) begin
						state_q <= S_PRT;
					end else begin
						state_q <= S_RD;
					end
				end
				S_PRT: state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					in_q <= in_data;
				end
			end
			S_SRCH: begin
				k_q       <= '0;
				present_q <= 1'b0;
				if (tok[SOURCE_ENTRIES].hit) begin
					slot_q <= IW'(tok[SOURCE_ENTRIES].hit_idx);
					cnt_q  <= tok[SOURCE_ENTRIES].count;
					blk_q  <= tok[SOURCE_ENTRIES].blocked;
					fill_q <= FW'(tok[SOURCE_ENTRIES].fill);
					full_q <= 1'b0;
				end else begin
					// allocate the lowest free entry, or flag a full table
					slot_q <= IW'(tok[SOURCE_ENTRIES].free_idx);
					cnt_q  <= '0;
					blk_q  <= 1'b0;
					fill_q <= '0;
					full_q <= !tok[SOURCE_ENTRIES].free;
				end
			end
			S_CMP: begin
				k_q <= k1;
				if (rdata == in_q.dst_port) begin
					present_q <= 1'b1;
				end
			end
			S_PRT: begin
				if (full_q) begin
					res_q.flood_alert    <= 1'b0;
					res_q.scan_alert     <= 1'b0;
					res_q.large_alert    <= oversize;
					res_q.newly_blocked  <= 1'b0;
					res_q.source_blocked <= 1'b0;
					res_q.table_full     <= 1'b1;
				end else begin
					res_q.flood_alert    <= flood;
					res_q.scan_alert     <= scan;
					res_q.large_alert    <= oversize;
					res_q.newly_blocked  <= alert && !blk_q;
					res_q.source_blocked <= alert || blk_q;
					res_q.table_full     <= 1'b0;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end
endmodule

// File: hw/rtl/sfsd_checker.sv
// Port-level checker for the detector, bound to the top level.
module sfsd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input sfsd_pkg::sfsd_out_t out_data
);
	import sfsd_pkg::*;

	// One transaction at a time: no second acceptance right after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted twice in a row");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("result dropped or changed while stalled");

	a_full_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.table_full) |-> (!out_data.flood_alert &&
		!out_data.scan_alert && !out_data.newly_blocked && !out_data.source_blocked))
		else $error("full table result carries source state");

	a_newly: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.newly_blocked) |-> (out_data.source_blocked &&
		(out_data.flood_alert || out_data.scan_alert || out_data.large_alert)))
		else $error("new block without an alert");
endmodule

bind source_flood_scan_detector sfsd_checker u_sfsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// File: test/source_flood_scan_detector_tb.sv
// Testbench for the source flood and scan detector: directed and random packet headers.
module source_flood_scan_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sfsd_pkg::*;

	localparam int ENTRIES = 64;
	localparam int PORTS = 32;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int SETTLE = 160;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	sfsd_in_t in_data;
	sfsd_out_t out_data;

	source_flood_scan_detector DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Detector state mirror
	logic [15:0] flood_thr, large_lim;
	logic [4:0] scan_thr;
	logic ent_used [ENTRIES];
	logic [31:0] ent_addr [ENTRIES];
	logic [16:0] ent_cnt [ENTRIES];
	logic ent_blk [ENTRIES];
	logic [15:0] ent_ports [ENTRIES][PORTS];
	int ent_fill [ENTRIES];

	sfsd_in_t headers_pending[$];
	sfsd_out_t alerts_due[$];
	int mismatches = 0;
	bit quiet = 0;
	int send_gap = 0, recv_gap = 0;
	logic [31:0] addr_pool [80];

	function automatic sfsd_out_t classify(sfsd_in_t h);
		sfsd_out_t r;
		int slot;
		bit present;
		r = '0;
		slot = -1;
		present = 0;
		r.large_alert = h.pkt_length > large_lim;
		for (int i = 0; i < ENTRIES; i++)
			if (slot < 0 && ent_used[i] && ent_addr[i] == h.src_addr) slot = i;
		if (slot < 0) begin
			for (int i = 0; i < ENTRIES; i++)
				if (slot < 0 && !ent_used[i]) slot = i;
			if (slot >= 0) begin
				ent_used[slot] = 1;
				ent_addr[slot] = h.src_addr;
				ent_cnt[slot] = '0;
				ent_blk[slot] = 0;
				ent_fill[slot] = 0;
			end
		end
		if (slot < 0) begin
			r.table_full = 1;
			return r;
		end
		ent_cnt[slot] = ent_cnt[slot] + 17'd1;
		if (ent_cnt[slot] > {1'b0, flood_thr}) begin
			r.flood_alert = 1;
			ent_cnt[slot] = '0;
		end
		for (int k = 0; k < ent_fill[slot]; k++)
			if (ent_ports[slot][k] == h.dst_port) present = 1;
		if (!present && ent_fill[slot] < PORTS) begin
			ent_ports[slot][ent_fill[slot]] = h.dst_port;
			ent_fill[slot]++;
		end
		if (ent_fill[slot] > scan_thr) begin
			r.scan_alert = 1;
			ent_fill[slot] = 0;
		end
		if ((r.flood_alert || r.scan_alert || r.large_alert) && !ent_blk[slot]) begin
			ent_blk[slot] = 1;
			r.newly_blocked = 1;
		end
		r.source_blocked = ent_blk[slot];
		return r;
	endfunction

	// Header driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready) begin
				alerts_due.push_back(classify(in_data));
				if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 8);
			end
			if (!(in_valid && !in_ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (headers_pending.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= headers_pending.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Alert monitor
	always @(posedge clk or negedge arst_n) begin
		sfsd_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (alerts_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %b", out_data);
				end else begin
					want = alerts_due.pop_front();
					if (want !== out_data) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %b actual %b (flood scan large new blk full)",
								want, out_data);
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 7);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic add_pkt(logic [31:0] a, logic [15:0] p, logic [15:0] l);
		sfsd_in_t h;
		h.src_addr = a;
		h.dst_port = p;
		h.pkt_length = l;
		headers_pending.push_back(h);
	endtask

	task automatic drain();
		do @(posedge clk);
		while (headers_pending.size() != 0 || in_valid || alerts_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!(cfg_valid && cfg_ready));
		case (idx)
			CFG_FLOOD_THR: flood_thr = val;
			CFG_SCAN_THR:  scan_thr = val[4:0];
			CFG_LARGE:     large_lim = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_burst(int n);
		logic [31:0] a;
		logic [15:0] p, l;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: a = $urandom;
				1, 2: a = addr_pool[$urandom_range(0, 79)];
				default: a = addr_pool[$urandom_range(0, 15)];
			endcase
			p = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
			case ($urandom_range(0, 3))
				0: l = 16'($urandom);
				1: l = large_lim + 16'($urandom_range(0, 2)) - 16'd1;
				default: l = 16'($urandom_range(0, 1600));
			endcase
			add_pkt(a, p, l);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FLOOD_THR;
		cfg_data = '0;
		flood_thr = 16'd100;
		scan_thr = 5'd10;
		large_lim = 16'd1500;
		foreach (ent_used[i]) ent_used[i] = 0;
		addr_pool[0] = 32'h0;
		addr_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 80; i++) addr_pool[i] = $urandom;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, large boundary, repeats and distinct ports
		add_pkt(32'h0, 16'h0, 16'h0);
		add_pkt(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		add_pkt(32'h0, 16'h0, 16'd1500);
		add_pkt(32'h0, 16'h1, 16'd1501);
		add_pkt(32'h0, 16'h1, 16'd0);
		for (int i = 0; i < 12; i++) add_pkt(32'h0A00_0001, 16'(i * 5461), 16'd64);
		drain();

		// thresholds at zero, and a write to an unused index
		write_reg(CFG_FLOOD_THR, 16'd0);
		write_reg(CFG_SCAN_THR, 16'd0);
		write_reg(CFG_LARGE, 16'd0);
		write_reg(CFG_UNUSED, 16'hFFFF);
		add_pkt(32'h0A00_0001, 16'd7, 16'd0);
		add_pkt(32'h0A00_0001, 16'd7, 16'd1);
		random_burst(150);
		drain();

		// high extremes; the table fills up with fresh sources
		write_reg(CFG_FLOOD_THR, 16'hFFFF);
		write_reg(CFG_SCAN_THR, 16'd31);
		write_reg(CFG_LARGE, 16'hFFFF);
		for (int i = 0; i < 40; i++) add_pkt(32'hC0A8_0000 + i, 16'(i), 16'hFFFF);
		for (int i = 0; i < 34; i++) add_pkt(32'h0000_0000, 16'(1000 + i), 16'd10);
		random_burst(130);
		drain();

		write_reg(CFG_FLOOD_THR, 16'd3);
		write_reg(CFG_SCAN_THR, 16'd4);
		write_reg(CFG_LARGE, 16'd1000);
		random_burst(150);
		drain();

		write_reg(CFG_FLOOD_THR, 16'd7);
		write_reg(CFG_SCAN_THR, 16'd2);
		write_reg(CFG_LARGE, 16'd100);
		quiet = 1;
		random_burst(100);
		drain();

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end
endmodule
